@@ hdl/esf_pkg.sv @@
// Shared types and constants for the escape stuffing framer.
`timescale 1ns / 1ps
`default_nettype none
package esf_pkg;

  // Input word kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindFinal   = 2'd1;
  localparam logic [1:0] KindClose   = 2'd2;

  // Register indexes on the APB port (word address = paddr[3:2])
  localparam logic [1:0] RegEscape = 2'd0;
  localparam logic [1:0] RegStart  = 2'd1;
  localparam logic [1:0] RegFinish = 2'd2;

  localparam int unsigned PaddrW = 4;

  // Reset values of the registers
  localparam logic [7:0] EscapeReset = 8'h10;
  localparam logic [7:0] StartReset  = 8'h02;
  localparam logic [7:0] FinishReset = 8'h03;

  // Output byte steps, one bit each, sent lowest bit first
  localparam int unsigned OpHdrEsc   = 0;
  localparam int unsigned OpHdrStart = 1;
  localparam int unsigned OpStuffEsc = 2;
  localparam int unsigned OpData     = 3;
  localparam int unsigned OpTrlEsc   = 4;
  localparam int unsigned OpTrlFin   = 5;
  localparam int unsigned NumOps     = 6;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] start_char;
    logic [7:0] finish_char;
  } cfg_t;

  // Queue entry: the steps to run and the payload byte
  typedef struct packed {
    logic [NumOps-1:0] ops;
    logic [7:0]        data_byte;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/esf_front.sv @@
// Front end: accepts input words, tracks the open frame, builds step masks.
`timescale 1ns / 1ps
`default_nettype none
module esf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire esf_pkg::in_word_t in_word_i,
  input  wire esf_pkg::cfg_t   cfg_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output esf_pkg::cmd_t        push_cmd_o
);
  import esf_pkg::*;

  logic frame_open_q, frame_open_d;
  logic accept;
  logic meaningful;
  logic has_data;
  logic closes;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the word
  always_comb begin
    meaningful = (in_word_i.kind == KindPayload) || (in_word_i.kind == KindFinal) ||
                 (in_word_i.kind == KindClose);
    has_data   = (in_word_i.kind == KindPayload) || (in_word_i.kind == KindFinal);
    closes     = (in_word_i.kind == KindFinal) || (in_word_i.kind == KindClose);

    push_cmd_o.ops                = '0;
    push_cmd_o.ops[OpHdrEsc]      = !frame_open_q;
    push_cmd_o.ops[OpHdrStart]    = !frame_open_q;
    push_cmd_o.ops[OpStuffEsc]    = has_data && (in_word_i.data_byte == cfg_i.escape_byte);
    push_cmd_o.ops[OpData]        = has_data;
    push_cmd_o.ops[OpTrlEsc]      = closes;
    push_cmd_o.ops[OpTrlFin]      = closes;
    push_cmd_o.data_byte          = in_word_i.data_byte;

    push_o = accept && meaningful;

    frame_open_d = frame_open_q;
    if (push_o) begin
      frame_open_d = !closes;
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/esf_queue.sv @@
// Small register queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module esf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire esf_pkg::cmd_t push_cmd_i,
  input  wire logic          pop_i,
  output esf_pkg::cmd_t      head_o,
  output logic               empty_o,
  output logic               full_o
);
  import esf_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull) else $error("queue count above depth");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow push");

endmodule
`default_nettype wire

@@ hdl/esf_back.sv @@
// Back end: runs the step mask of each queued word, one output byte a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module esf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire esf_pkg::cfg_t cfg_i,
  input  wire esf_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output esf_pkg::out_word_t out_word_o
);
  import esf_pkg::*;

  logic [NumOps-1:0] ops_q, ops_d;
  logic [7:0]        data_q, data_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;
  logic [NumOps-1:0] sel;
  logic [NumOps-1:0] rest;
  logic              adv, emit;
  logic [7:0]        byte_sel;

  // Lowest pending step goes next
  always_comb begin
    sel = ops_q & (~ops_q + 1'b1);
    rest = ops_q & ~sel;
    priority if (sel[OpHdrEsc] || sel[OpStuffEsc] || sel[OpTrlEsc]) begin
      byte_sel = cfg_i.escape_byte;
    end else if (sel[OpHdrStart]) begin
      byte_sel = cfg_i.start_char;
    end else if (sel[OpTrlFin]) begin
      byte_sel = cfg_i.finish_char;
    end else begin
      byte_sel = data_q;
    end
  end

  // Step control and output register
  always_comb begin
    adv   = !out_valid_q || !out_stall_i;
    emit  = adv && (ops_q != '0);
    pop_o = ((ops_q == '0) || (emit && rest == '0)) && !empty_i;

    ops_d  = ops_q;
    data_d = data_q;
    if (pop_o) begin
      ops_d  = head_i.ops;
      data_d = head_i.data_byte;
    end else if (emit) begin
      ops_d = rest;
    end

    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (emit) begin
      out_valid_d            = 1'b1;
      out_word_d.out_byte    = byte_sel;
      out_word_d.last_of_run = (rest == '0);
      out_word_d.frame_end   = sel[OpTrlFin];
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ops_q       <= ops_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.frame_end) |-> out_word_q.last_of_run)
    else $error("frame end byte not last of its run");
  a_pop_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (ops_q == '0 || rest == '0)) else $error("pop while steps remain");

endmodule
`default_nettype wire

@@ hdl/escape_stuffing_framer.sv @@
// Top level of the escape stuffing framer: registers, front end, queue, back end.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one word a cycle:
//   kind 0 payload byte, 1 final payload byte, 2 close frame with no byte,
//   kind 3 is taken and dropped. The first word of a frame adds escape + start,
//   a closing word adds escape + finish, a payload byte equal to escape is doubled.
//   Output channel (out_valid_o / out_stall_i / out_word_o) gives one byte a cycle;
//   last_of_run marks the last byte of a word, frame_end the finish marker.
//   A taken word goes through the queue, step register and output register.
//   Throughput: one output byte per cycle while out_stall_i is low, set by the
//   back-end step sequencer; a word makes 1 to 6 output bytes.
//   The front end keeps taking words into a QueueDepth-entry queue while the
//   output stalls; in_stall_o rises only when that queue is full.
//   Registers escape_byte, start_char, finish_char sit at 0x0, 0x4, 0x8 on the
//   APB port; write them only while the block is idle.
//   Reset clears the queue, the output valid flag and the open-frame flag, and
//   loads 0x10, 0x02, 0x03 into the registers.
`timescale 1ns / 1ps
`default_nettype none
module escape_stuffing_framer #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire esf_pkg::in_word_t         in_word_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output esf_pkg::out_word_t             out_word_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [esf_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import esf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push, pop, q_full, q_empty;
  cmd_t       push_cmd, head;

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegEscape: cfg_d.escape_byte = pwdata[7:0];
        RegStart:  cfg_d.start_char  = pwdata[7:0];
        RegFinish: cfg_d.finish_char = pwdata[7:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegEscape: prdata = {24'd0, cfg_q.escape_byte};
      RegStart:  prdata = {24'd0, cfg_q.start_char};
      RegFinish: prdata = {24'd0, cfg_q.finish_char};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_byte <= EscapeReset;
      cfg_q.start_char  <= StartReset;
      cfg_q.finish_char <= FinishReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  esf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  esf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  esf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
